// ----- sv/bmlc_pkg.sv -----
// Package for the two-light controller: field widths, mode codes, button codes
// and configuration register indexes. No dependencies.
package bmlc_pkg;

    localparam int ELAPSED_W  = 8;
    localparam int BUTTON_W   = 2;
    localparam int MODE_W     = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;
    localparam int LONG_MS_W  = 24;
    localparam int STEP_MS_W  = 16;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [BUTTON_W-1:0] button_t;

    // button modes: bit 0 main, bit 1 niche
    localparam mode_t MODE_OFF   = 4'd0;
    localparam mode_t MODE_MAIN  = 4'd1;
    localparam mode_t MODE_NICHE = 4'd2;
    localparam mode_t MODE_BOTH  = 4'd3;
    // lamp test steps
    localparam mode_t MODE_TEST_FIRST = 4'd4;
    localparam mode_t MODE_TEST_BOTH  = 4'd5;
    localparam mode_t MODE_TEST_NICHE = 4'd6;
    localparam mode_t MODE_TEST_NONE  = 4'd7;
    localparam mode_t MODE_TEST_LAST  = 4'd8;

    localparam button_t BTN_NONE  = 2'd0;
    localparam button_t BTN_SHORT = 2'd1;
    localparam button_t BTN_LONG  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_OFF    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOTION_HOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP        = 2'd2;

    localparam logic [LONG_MS_W-1:0] AUTO_OFF_RESET    = 24'd7200000;
    localparam logic [LONG_MS_W-1:0] MOTION_HOLD_RESET = 24'd120000;
    localparam logic [STEP_MS_W-1:0] STEP_RESET        = 16'd1010;

endpackage

// ----- sv/button_motion_light_controller.sv -----
// Two-light controller with power-up lamp test, button modes, auto-off and
// motion hold. Depends on bmlc_pkg.
//
// Usage: each input word on in_valid/in_stall is one control pass (elapsed
// milliseconds, button event, motion level, switch-off). Every pass yields
// exactly one result word on out_valid/out_stall carrying the two relay drives
// and the motion hold flag.
// Each word passes the input register, then the state update that also loads
// the result register. Throughput is one word per cycle while out_stall is
// low; the limit is the state update (two saturating 24-bit
// countdowns plus the mode logic).
// Reset (rst_n low, asynchronous) clears the pipeline, restores the register
// defaults and arms the five-step lamp test, which then runs on the first
// passes. Configuration is written via cfg_we/cfg_index/cfg_data; the user
// must do so only while the block is idle (not enforced); index 3 is ignored.
// With out_valid and out_stall high, the result word and all state hold; the
// input register still takes one word, and in_stall rises once it is full.
module button_motion_light_controller #(
    parameter int TIMER_BITS = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [bmlc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bmlc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [bmlc_pkg::ELAPSED_W-1:0] elapsed_ms,
    input  logic [bmlc_pkg::BUTTON_W-1:0]  button_event,
    input  logic                           motion,
    input  logic                           switch_off,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic                           main_light,
    output logic                           niche_light,
    output logic                           motion_hold_active
);
    import bmlc_pkg::*;

    localparam int LW = (TIMER_BITS > LONG_MS_W) ? TIMER_BITS : LONG_MS_W;
    localparam logic [LW-1:0] TMAX = LW'((64'd1 << TIMER_BITS) - 64'd1);

    typedef logic [TIMER_BITS-1:0] timer_t;

    function automatic timer_t load_timer(input logic [LONG_MS_W-1:0] v);
        logic [LW-1:0] ve;
        ve = LW'(v);
        return (ve > TMAX) ? TIMER_BITS'(TMAX) : TIMER_BITS'(ve);
    endfunction

    function automatic timer_t count_down(input timer_t t,
                                          input logic [ELAPSED_W-1:0] d);
        timer_t de;
        de = TIMER_BITS'(d);
        return (t > de) ? t - de : '0;
    endfunction

    // configuration
    logic [LONG_MS_W-1:0] auto_off_ms_reg;
    logic [LONG_MS_W-1:0] motion_hold_ms_reg;
    logic [STEP_MS_W-1:0] step_ms_reg;

    // input register
    logic                 s1_valid_reg;
    logic [ELAPSED_W-1:0] s1_elapsed_reg;
    button_t              s1_button_reg;
    logic                 s1_motion_reg;
    logic                 s1_off_reg;

    // state and result
    logic   out_valid_reg;
    mode_t  mode_reg,  mode_next;
    logic   held_reg,  held_next;
    timer_t auto_reg,  auto_next;
    timer_t hold_reg,  hold_next;
    logic   main_reg,  main_next;
    logic   niche_reg, niche_next;

    logic advance;
    logic s1_load;

    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !advance;
    assign s1_load  = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_off_ms_reg    <= AUTO_OFF_RESET;
            motion_hold_ms_reg <= MOTION_HOLD_RESET;
            step_ms_reg        <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_AUTO_OFF:    auto_off_ms_reg    <= cfg_data;
                CFG_MOTION_HOLD: motion_hold_ms_reg <= cfg_data;
                CFG_STEP:        step_ms_reg        <= cfg_data[STEP_MS_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_elapsed_reg <= elapsed_ms;
            s1_button_reg  <= button_event;
            s1_motion_reg  <= motion;
            s1_off_reg     <= switch_off;
        end
    end

    always_comb
    begin
        auto_next  = count_down(auto_reg, s1_elapsed_reg);
        hold_next  = count_down(hold_reg, s1_elapsed_reg);
        mode_next  = mode_reg;
        held_next  = held_reg;
        main_next  = main_reg;
        niche_next = niche_reg;

        if (s1_off_reg)
        begin
            mode_next = MODE_OFF;
            held_next = 1'b0;
        end
        if (mode_next > MODE_TEST_LAST)
        begin
            mode_next = MODE_OFF;
        end

        if (mode_next < MODE_TEST_FIRST)
        begin
            case (s1_button_reg)
                BTN_SHORT:
                begin
                    auto_next = load_timer(auto_off_ms_reg);
                    case (mode_next)
                        MODE_OFF:   mode_next = MODE_NICHE;
                        MODE_NICHE: mode_next = MODE_BOTH;
                        MODE_BOTH:  mode_next = MODE_MAIN;
                        default:    mode_next = MODE_OFF;
                    endcase
                end
                BTN_LONG:
                begin
                    auto_next = load_timer(auto_off_ms_reg);
                    mode_next = (mode_next == MODE_OFF) ? MODE_BOTH : MODE_OFF;
                end
                default: ;
            endcase
            if (auto_next == '0)
            begin
                mode_next = MODE_OFF;
            end

            if (mode_next != MODE_OFF)
            begin
                held_next = 1'b0;
            end
            else if (s1_motion_reg)
            begin
                held_next = 1'b1;
                hold_next = load_timer(motion_hold_ms_reg);
            end
            else if (held_next && hold_next == '0)
            begin
                held_next = 1'b0;
            end
            main_next  = mode_next[0];
            niche_next = mode_next[1] || held_next;
        end
        else if (mode_next == MODE_TEST_FIRST)
        begin
            main_next  = 1'b1;
            niche_next = 1'b0;
            auto_next  = load_timer(LONG_MS_W'(step_ms_reg));
            mode_next  = MODE_TEST_BOTH;
        end
        else if (auto_next == '0)
        begin
            case (mode_next)
                MODE_TEST_BOTH:
                begin
                    main_next  = 1'b1;
                    niche_next = 1'b1;
                end
                MODE_TEST_NICHE:
                begin
                    main_next  = 1'b0;
                    niche_next = 1'b1;
                end
                MODE_TEST_NONE:
                begin
                    main_next  = 1'b0;
                    niche_next = 1'b0;
                end
                default: ;
            endcase
            if (mode_next == MODE_TEST_LAST)
            begin
                mode_next = MODE_OFF;
            end
            else
            begin
                auto_next = load_timer(LONG_MS_W'(step_ms_reg));
                mode_next = mode_next + mode_t'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_TEST_FIRST;
            held_reg      <= 1'b0;
            auto_reg      <= '0;
            hold_reg      <= '0;
            main_reg      <= 1'b0;
            niche_reg     <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                held_reg      <= held_next;
                auto_reg      <= auto_next;
                hold_reg      <= hold_next;
                main_reg      <= main_next;
                niche_reg     <= niche_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // relay and hold state double as the result word; they only move on advance
    assign out_valid          = out_valid_reg;
    assign main_light         = main_reg;
    assign niche_light        = niche_reg;
    assign motion_hold_active = held_reg;

endmodule
